[hdl/bdlp_pkg.sv]
// Shared types and constants for the button debounce and long press detector.
`default_nettype none
package bdlp_pkg;

  localparam int unsigned REG_WIDTH   = 16;
  localparam int unsigned INDEX_WIDTH = 1;
  localparam int unsigned EVENT_WIDTH = 2;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_PRESS_DB   = 2'd1,
    MODE_RELEASE_DB = 2'd2,
    MODE_LONG_WATCH = 2'd3
  } mode_t;

  typedef enum logic [EVENT_WIDTH-1:0] {
    EVENT_NONE  = 2'd0,
    EVENT_SHORT = 2'd1,
    EVENT_LONG  = 2'd2
  } press_event_t;

  typedef enum logic [INDEX_WIDTH-1:0] {
    REG_DEBOUNCE_TICKS   = 1'd0,
    REG_LONG_PRESS_TICKS = 1'd1
  } reg_index_t;

  localparam logic [REG_WIDTH-1:0] DEBOUNCE_TICKS_RESET   = 16'd500;
  localparam logic [REG_WIDTH-1:0] LONG_PRESS_TICKS_RESET = 16'd10000;

endpackage
`default_nettype wire

[hdl/bdlp_in_if.sv]
// Input channel carrying one sampled button level per item.
`default_nettype none
interface bdlp_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface
`default_nettype wire

[hdl/bdlp_out_if.sv]
// Result channel carrying one press event per item.
`default_nettype none
interface bdlp_out_if;
  logic                             valid;
  logic                             ready;
  logic [bdlp_pkg::EVENT_WIDTH-1:0] press_event;

  modport source (output valid, output press_event, input ready);
  modport sink (input valid, input press_event, output ready);
endinterface
`default_nettype wire

[hdl/button_debounce_long_press.sv]
// Top level of the button debounce and short/long press detector.
//
// Each accepted item is one tick with the sampled button level, and each tick yields
// exactly one result item: none, short press or long press. The mode, tick counter and
// previous level update in the cycle the item is accepted, so one item per cycle is
// taken while ready is high. A two-entry output stage lets the input
// keep accepting while one result waits, and input ready drops only when both entries
// are full. The counter is COUNT_WIDTH bits wide and wraps; limits are cut or
// zero-extended to that width. Configuration writes take effect on the next item.
`default_nettype none
module button_debounce_long_press #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  bdlp_in_if.sink                             in_ch,
  bdlp_out_if.source                          out_ch,
  input  wire                                 cfg_we,
  input  wire [bdlp_pkg::INDEX_WIDTH-1:0]     cfg_index,
  input  wire [bdlp_pkg::REG_WIDTH-1:0]       cfg_wdata
);

  logic [bdlp_pkg::REG_WIDTH-1:0] debounce_ticks_r;
  logic [bdlp_pkg::REG_WIDTH-1:0] long_press_ticks_r;

  bdlp_pkg::mode_t        mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   last_level_r;

  bdlp_pkg::press_event_t event_nxt;
  bdlp_pkg::press_event_t out_data_r, out_data_nxt;
  bdlp_pkg::press_event_t skid_data_r, skid_data_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   skid_valid_r, skid_valid_nxt;

  logic                   in_fire;
  logic                   out_fire;
  logic                   level;
  bdlp_pkg::mode_t        mode_edge;
  logic [COUNT_WIDTH-1:0] count_edge;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [COUNT_WIDTH-1:0] limit;

  assign level        = in_ch.pin_level;
  assign in_ch.ready  = !skid_valid_r;
  assign in_fire      = in_ch.valid && !skid_valid_r;
  assign out_fire     = out_valid_r && out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.press_event = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= bdlp_pkg::DEBOUNCE_TICKS_RESET;
      long_press_ticks_r <= bdlp_pkg::LONG_PRESS_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bdlp_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks_r   <= cfg_wdata;
        bdlp_pkg::REG_LONG_PRESS_TICKS: long_press_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_edge  = mode_r;
    count_edge = count_r;
    event_nxt  = bdlp_pkg::EVENT_NONE;
    if (level != last_level_r &&
        (mode_r == bdlp_pkg::MODE_IDLE || mode_r == bdlp_pkg::MODE_LONG_WATCH)) begin
      if (level && mode_r == bdlp_pkg::MODE_IDLE) begin
        mode_edge = bdlp_pkg::MODE_PRESS_DB;
      end else begin
        if (mode_r == bdlp_pkg::MODE_LONG_WATCH) begin
          event_nxt = bdlp_pkg::EVENT_SHORT;
        end
        mode_edge = bdlp_pkg::MODE_RELEASE_DB;
      end
      count_edge = '0;
    end

    limit     = (mode_edge == bdlp_pkg::MODE_LONG_WATCH) ?
                COUNT_WIDTH'(long_press_ticks_r) : COUNT_WIDTH'(debounce_ticks_r);
    count_inc = count_edge + COUNT_WIDTH'(1);
    mode_nxt  = mode_edge;
    count_nxt = count_edge;

    if (mode_edge != bdlp_pkg::MODE_IDLE) begin
      count_nxt = count_inc;
      if (count_inc == limit) begin
        case (mode_edge)
          bdlp_pkg::MODE_PRESS_DB: begin
            mode_nxt  = level ? bdlp_pkg::MODE_LONG_WATCH : bdlp_pkg::MODE_RELEASE_DB;
            count_nxt = '0;
          end
          bdlp_pkg::MODE_RELEASE_DB: begin
            mode_nxt  = bdlp_pkg::MODE_IDLE;
            count_nxt = '0;
          end
          bdlp_pkg::MODE_LONG_WATCH: begin
            if (level) begin
              event_nxt = bdlp_pkg::EVENT_LONG;
              mode_nxt  = bdlp_pkg::MODE_IDLE;
              count_nxt = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= bdlp_pkg::MODE_IDLE;
      count_r      <= '0;
      last_level_r <= 1'b0;
    end else if (in_fire) begin
      mode_r       <= mode_nxt;
      count_r      <= count_nxt;
      last_level_r <= level;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_fire || !out_valid_r) begin
      out_valid_nxt  = skid_valid_r || in_fire;
      out_data_nxt   = skid_valid_r ? skid_data_r : event_nxt;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = event_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
`default_nettype wire
